@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file of the replacement tracker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LPR_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lpr check failed");

// Next-cycle implication, disabled while reset is asserted.
`define LPR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lpr check failed");

// Next-cycle implication that is also checked across reset.
`define LPR_ASSERT_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("lpr check failed");

`endif

@@ rtl/lpr_pkg.sv @@
// Shared codes, widths and types of the LRU page replacement tracker.
package lpr_pkg;

    localparam int OP_W   = 2;
    localparam int ST_W   = 2;
    localparam int PROC_W = 16;
    localparam int PAGE_W = 32;

    localparam logic [OP_W-1:0] OP_ACCESS = 2'd0;
    localparam logic [OP_W-1:0] OP_SELECT = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_MISS  = 2'd2;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd3;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [PROC_W-1:0] victim_process;
        logic [PAGE_W-1:0] victim_page;
    } t_result;

endpackage

@@ rtl/lpr_mem.sv @@
// Entry table memory with one write port and one registered read port.
module lpr_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 52
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/lpr_seq.sv @@
// Sequencer that scans and updates the entry table one entry per cycle.
module lpr_seq #(
    parameter int NUM_ENTRIES = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_start,
    input  logic [lpr_pkg::OP_W-1:0]              i_operation,
    input  logic [lpr_pkg::PROC_W-1:0]            i_process_id,
    input  logic [lpr_pkg::PAGE_W-1:0]            i_page_number,
    output logic                                  o_idle,
    output logic                                  o_done,
    input  logic                                  i_take,
    output lpr_pkg::t_result                      o_result,
    output logic [$clog2(NUM_ENTRIES)-1:0]        o_rd_addr,
    input  logic [lpr_pkg::PROC_W+lpr_pkg::PAGE_W+$clog2(NUM_ENTRIES)-1:0] i_rd_data,
    output logic                                  o_wr_en,
    output logic [$clog2(NUM_ENTRIES)-1:0]        o_wr_addr,
    output logic [lpr_pkg::PROC_W+lpr_pkg::PAGE_W+$clog2(NUM_ENTRIES)-1:0] o_wr_data
);

    localparam int IW = $clog2(NUM_ENTRIES);
    localparam int RW = IW;
    localparam int CW = $clog2(NUM_ENTRIES + 1);
    localparam logic [IW:0]   END_IDX  = (IW + 1)'(NUM_ENTRIES);
    localparam logic [CW-1:0] FULL_CNT = CW'(NUM_ENTRIES);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SCAN   = 4'b0010,
        S_UPDATE = 4'b0100,
        S_DONE   = 4'b1000
    } t_state;

    t_state                     r_state, n_state;
    logic [lpr_pkg::OP_W-1:0]   r_op, n_op;
    logic [lpr_pkg::PROC_W-1:0] r_proc, n_proc;
    logic [lpr_pkg::PAGE_W-1:0] r_page, n_page;
    logic [IW:0]                r_idx, n_idx;
    logic                       r_rd_live, n_rd_live;
    logic [IW-1:0]              r_rd_idx, n_rd_idx;
    logic [NUM_ENTRIES-1:0]     r_valid, n_valid;
    logic [CW-1:0]              r_count, n_count;
    logic                       r_found, n_found;
    logic [IW-1:0]              r_hit_idx, n_hit_idx;
    logic [RW-1:0]              r_hit_rank, n_hit_rank;
    logic                       r_free_found, n_free_found;
    logic [IW-1:0]              r_free_idx, n_free_idx;
    lpr_pkg::t_result           r_result, n_result;

    logic                       issue;
    logic                       e_valid;
    logic [lpr_pkg::PROC_W-1:0] rd_proc;
    logic [lpr_pkg::PAGE_W-1:0] rd_page;
    logic [RW-1:0]              rd_rank;
    logic [CW-1:0]              cnt_m1;
    logic                       key_eq;
    logic                       victim_eq;
    logic                       rank_lt;
    logic                       rank_gt;
    logic [RW-1:0]              rank_inc;
    logic [RW-1:0]              rank_dec;

    assign issue = ((r_state == S_SCAN) || (r_state == S_UPDATE)) && (r_idx != END_IDX);
    assign {rd_proc, rd_page, rd_rank} = i_rd_data;
    assign e_valid   = r_valid[r_rd_idx];
    assign cnt_m1    = r_count - CW'(1);
    assign key_eq    = (rd_proc == r_proc) && (rd_page == r_page);
    assign victim_eq = (rd_rank == cnt_m1[RW-1:0]);
    assign rank_lt   = (rd_rank < r_hit_rank);
    assign rank_gt   = (rd_rank > r_hit_rank);
    assign rank_inc  = rd_rank + RW'(1);
    assign rank_dec  = rd_rank - RW'(1);

    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_proc       = r_proc;
        n_page       = r_page;
        n_idx        = r_idx;
        n_rd_live    = issue;
        n_rd_idx     = r_idx[IW-1:0];
        n_valid      = r_valid;
        n_count      = r_count;
        n_found      = r_found;
        n_hit_idx    = r_hit_idx;
        n_hit_rank   = r_hit_rank;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_result     = r_result;
        o_wr_en      = 1'b0;
        o_wr_data    = {rd_proc, rd_page, rd_rank};
        if (issue) begin
            n_idx = r_idx + (IW + 1)'(1);
        end
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state      = S_SCAN;
                    n_op         = i_operation;
                    n_proc       = i_process_id;
                    n_page       = i_page_number;
                    n_idx        = '0;
                    n_found      = 1'b0;
                    n_free_found = 1'b0;
                    n_result     = '0;
                end
            end
            S_SCAN: begin
                if (r_rd_live) begin
                    if (!r_found && e_valid &&
                        ((r_op == lpr_pkg::OP_SELECT) ? victim_eq : key_eq)) begin
                        n_found    = 1'b1;
                        n_hit_idx  = r_rd_idx;
                        n_hit_rank = rd_rank;
                        if (r_op == lpr_pkg::OP_SELECT) begin
                            n_result.victim_process = rd_proc;
                            n_result.victim_page    = rd_page;
                        end
                    end
                    if (!r_free_found && !e_valid) begin
                        n_free_found = 1'b1;
                        n_free_idx   = r_rd_idx;
                    end
                end else if (r_idx == END_IDX) begin
                    n_idx = '0;
                    case (r_op)
                        lpr_pkg::OP_ACCESS: begin
                            if (r_found) begin
                                n_state = S_UPDATE;
                            end else if (r_count == FULL_CNT) begin
                                n_result.status = lpr_pkg::ST_FULL;
                                n_state         = S_DONE;
                            end else begin
                                n_count = r_count + CW'(1);
                                n_state = S_UPDATE;
                            end
                        end
                        lpr_pkg::OP_SELECT: begin
                            if (r_found) begin
                                n_valid[r_hit_idx] = 1'b0;
                                n_count            = cnt_m1;
                            end else begin
                                n_result.status = lpr_pkg::ST_EMPTY;
                            end
                            n_state = S_DONE;
                        end
                        lpr_pkg::OP_REMOVE: begin
                            if (r_found) begin
                                n_valid[r_hit_idx] = 1'b0;
                                n_count            = cnt_m1;
                                n_state            = S_UPDATE;
                            end else begin
                                n_result.status = lpr_pkg::ST_MISS;
                                n_state         = S_DONE;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_UPDATE: begin
                if (r_rd_live) begin
                    if ((r_op == lpr_pkg::OP_ACCESS) && !r_found) begin
                        if (r_rd_idx == r_free_idx) begin
                            o_wr_en            = 1'b1;
                            o_wr_data          = {r_proc, r_page, {RW{1'b0}}};
                            n_valid[r_rd_idx]  = 1'b1;
                        end else if (e_valid) begin
                            o_wr_en   = 1'b1;
                            o_wr_data = {rd_proc, rd_page, rank_inc};
                        end
                    end else if (r_op == lpr_pkg::OP_ACCESS) begin
                        if (r_rd_idx == r_hit_idx) begin
                            o_wr_en   = 1'b1;
                            o_wr_data = {rd_proc, rd_page, {RW{1'b0}}};
                        end else if (e_valid && rank_lt) begin
                            o_wr_en   = 1'b1;
                            o_wr_data = {rd_proc, rd_page, rank_inc};
                        end
                    end else begin
                        if (e_valid && rank_gt) begin
                            o_wr_en   = 1'b1;
                            o_wr_data = {rd_proc, rd_page, rank_dec};
                        end
                    end
                end else if (r_idx == END_IDX) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rd_live <= 1'b0;
            r_valid   <= '0;
            r_count   <= '0;
            r_idx     <= '0;
        end else begin
            r_state   <= n_state;
            r_rd_live <= n_rd_live;
            r_valid   <= n_valid;
            r_count   <= n_count;
            r_idx     <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_proc       <= n_proc;
        r_page       <= n_page;
        r_rd_idx     <= n_rd_idx;
        r_found      <= n_found;
        r_hit_idx    <= n_hit_idx;
        r_hit_rank   <= n_hit_rank;
        r_free_found <= n_free_found;
        r_free_idx   <= n_free_idx;
        r_result     <= n_result;
    end

    assign o_idle    = (r_state == S_IDLE);
    assign o_done    = (r_state == S_DONE);
    assign o_result  = r_result;
    assign o_rd_addr = r_idx[IW-1:0];
    assign o_wr_addr = r_rd_idx;

endmodule

@@ rtl/lru_page_replacement_tracker_unit.sv @@
// Top level of the LRU page replacement tracker with its result register.
//
//  Channel  Direction  Handshake          Payload
//  input    in         i_valid / o_stall  i_operation, i_process_id, i_page_number
//  output   out        o_valid / i_stall  o_status, o_victim_process, o_victim_page
//
// A select, a refused insert or a missed remove takes a scan of the table.
// An access that hits or inserts and a remove that hits add an update pass.
// The single read port of the entry table, one entry per cycle, paces each pass.
// Valid bits sit in flip-flops, so the block is ready right after reset.
// A new item is taken while an earlier result still waits behind a high i_stall.
module lru_page_replacement_tracker_unit #(
    parameter int NUM_ENTRIES = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [lpr_pkg::OP_W-1:0]   i_operation,
    input  logic [lpr_pkg::PROC_W-1:0] i_process_id,
    input  logic [lpr_pkg::PAGE_W-1:0] i_page_number,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [lpr_pkg::ST_W-1:0]   o_status,
    output logic [lpr_pkg::PROC_W-1:0] o_victim_process,
    output logic [lpr_pkg::PAGE_W-1:0] o_victim_page
);

    localparam int IW = $clog2(NUM_ENTRIES);
    localparam int MW = lpr_pkg::PROC_W + lpr_pkg::PAGE_W + IW;

    logic             seq_idle;
    logic             seq_done;
    logic             take;
    lpr_pkg::t_result seq_result;
    logic [IW-1:0]    rd_addr;
    logic [MW-1:0]    rd_data;
    logic             wr_en;
    logic [IW-1:0]    wr_addr;
    logic [MW-1:0]    wr_data;

    logic             r_out_valid, n_out_valid;
    lpr_pkg::t_result r_out, n_out;

    lpr_mem #(
        .DEPTH(NUM_ENTRIES),
        .WIDTH(MW)
    ) u_mem (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    lpr_seq #(
        .NUM_ENTRIES(NUM_ENTRIES)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (i_valid && seq_idle),
        .i_operation  (i_operation),
        .i_process_id (i_process_id),
        .i_page_number(i_page_number),
        .o_idle       (seq_idle),
        .o_done       (seq_done),
        .i_take       (take),
        .o_result     (seq_result),
        .o_rd_addr    (rd_addr),
        .i_rd_data    (rd_data),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data)
    );

    assign take = seq_done && (!r_out_valid || !i_stall);

    always_comb begin
        n_out_valid = r_out_valid && i_stall;
        n_out       = r_out;
        if (take) begin
            n_out_valid = 1'b1;
            n_out       = seq_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_stall          = !seq_idle;
    assign o_valid          = r_out_valid;
    assign o_status         = r_out.status;
    assign o_victim_process = r_out.victim_process;
    assign o_victim_page    = r_out.victim_page;

endmodule

@@ rtl/lpr_chk.sv @@
// Port-level checker of the LRU page replacement tracker and its bind.
`include "assert_macros.svh"

module lpr_chk (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_valid,
    input logic                       o_stall,
    input logic                       o_valid,
    input logic                       i_stall,
    input logic [lpr_pkg::ST_W-1:0]   o_status,
    input logic [lpr_pkg::PROC_W-1:0] o_victim_process,
    input logic [lpr_pkg::PAGE_W-1:0] o_victim_page
);

    logic [lpr_pkg::ST_W+lpr_pkg::PROC_W+lpr_pkg::PAGE_W-1:0] out_bus;
    logic                                                      out_err;
    logic                                                      victim_clear;

    assign out_bus      = {o_status, o_victim_process, o_victim_page};
    assign out_err      = o_valid && (o_status != lpr_pkg::ST_OK);
    assign victim_clear = (o_victim_process == '0) && (o_victim_page == '0);

    // A waiting result keeps its value until the transfer completes.
    `LPR_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(out_bus))

    // A result with an error status reports no victim.
    `LPR_ASSERT_NOW(a_victim_zero, i_clk, i_rst_n, out_err, victim_clear)

    // The table is busy in the cycle after an input transfer.
    `LPR_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, i_valid && !o_stall, o_stall)

    // Reset leaves no result pending and the input side open.
    `LPR_ASSERT_NEXT_ALWAYS(a_reset_clear, i_clk, !i_rst_n, !o_valid && !o_stall)

endmodule

bind lru_page_replacement_tracker_unit lpr_chk u_lpr_chk (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_valid         (i_valid),
    .o_stall         (o_stall),
    .o_valid         (o_valid),
    .i_stall         (i_stall),
    .o_status        (o_status),
    .o_victim_process(o_victim_process),
    .o_victim_page   (o_victim_page)
);

@@ dv/tb_lru_page_replacement_tracker_unit.sv @@
// Testbench of the LRU page replacement tracker with a directed table and random traffic.
module tb_lru_page_replacement_tracker_unit;

    localparam int NUM_ENTRIES = 16;
    localparam int RANK_W = $clog2(NUM_ENTRIES);
    localparam int POOL_SIZE = 24;
    localparam int RANDOM_ITEMS = 650;
    localparam logic [lpr_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct {
        logic [lpr_pkg::OP_W-1:0]   op;
        logic [lpr_pkg::PROC_W-1:0] proc;
        logic [lpr_pkg::PAGE_W-1:0] page;
        bit                         typed;
        lpr_pkg::t_result           want;
    } t_stim_row;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_valid = 1'b0;
    logic                       o_stall;
    logic [lpr_pkg::OP_W-1:0]   i_operation = '0;
    logic [lpr_pkg::PROC_W-1:0] i_process_id = '0;
    logic [lpr_pkg::PAGE_W-1:0] i_page_number = '0;
    logic                       o_valid;
    logic                       i_stall = 1'b0;
    logic [lpr_pkg::ST_W-1:0]   o_status;
    logic [lpr_pkg::PROC_W-1:0] o_victim_process;
    logic [lpr_pkg::PAGE_W-1:0] o_victim_page;

    logic                       resident[NUM_ENTRIES];
    logic [lpr_pkg::PROC_W-1:0] resident_proc[NUM_ENTRIES];
    logic [lpr_pkg::PAGE_W-1:0] resident_page[NUM_ENTRIES];
    logic [RANK_W-1:0]          resident_rank[NUM_ENTRIES];

    lpr_pkg::t_result           expected_results[$];
    t_stim_row                  directed_rows[$];
    logic [lpr_pkg::PROC_W-1:0] pool_proc[POOL_SIZE];
    logic [lpr_pkg::PAGE_W-1:0] pool_page[POOL_SIZE];
    int                         mismatch_count = 0;
    bit                         tx_calm = 1'b0;
    bit                         rx_calm = 1'b0;
    int                         rx_stall_left = 0;
    int                         hold_request = 0;

    lru_page_replacement_tracker_unit #(
        .NUM_ENTRIES(NUM_ENTRIES)
    ) DUT (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_operation(i_operation),
        .i_process_id(i_process_id),
        .i_page_number(i_page_number),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_status(o_status),
        .o_victim_process(o_victim_process),
        .o_victim_page(o_victim_page)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #4000000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic lpr_pkg::t_result lru_predict(logic [lpr_pkg::OP_W-1:0] op,
                                                     logic [lpr_pkg::PROC_W-1:0] proc,
                                                     logic [lpr_pkg::PAGE_W-1:0] page);
        lpr_pkg::t_result res;
        int hit;
        int slot;
        int oldest;
        int used;
        logic [RANK_W-1:0] r;
        res = '0;
        hit = -1;
        slot = -1;
        oldest = -1;
        used = 0;
        for (int i = 0; i < NUM_ENTRIES; i++) begin
            if (resident[i]) begin
                used++;
                if (hit < 0 && resident_proc[i] == proc && resident_page[i] == page)
                    hit = i;
            end
        end
        case (op)
            lpr_pkg::OP_ACCESS: begin
                if (hit >= 0) begin
                    r = resident_rank[hit];
                    for (int i = 0; i < NUM_ENTRIES; i++)
                        if (resident[i] && resident_rank[i] < r)
                            resident_rank[i]++;
                    resident_rank[hit] = '0;
                end else if (used >= NUM_ENTRIES) begin
                    res.status = lpr_pkg::ST_FULL;
                end else begin
                    for (int i = 0; i < NUM_ENTRIES; i++) begin
                        if (resident[i])
                            resident_rank[i]++;
                        else if (slot < 0)
                            slot = i;
                    end
                    resident[slot] = 1'b1;
                    resident_proc[slot] = proc;
                    resident_page[slot] = page;
                    resident_rank[slot] = '0;
                end
            end
            lpr_pkg::OP_SELECT: begin
                for (int i = 0; i < NUM_ENTRIES; i++)
                    if (resident[i] && (oldest < 0 || resident_rank[i] > resident_rank[oldest]))
                        oldest = i;
                if (oldest < 0) begin
                    res.status = lpr_pkg::ST_EMPTY;
                end else begin
                    res.victim_process = resident_proc[oldest];
                    res.victim_page = resident_page[oldest];
                    resident[oldest] = 1'b0;
                end
            end
            lpr_pkg::OP_REMOVE: begin
                if (hit < 0) begin
                    res.status = lpr_pkg::ST_MISS;
                end else begin
                    r = resident_rank[hit];
                    resident[hit] = 1'b0;
                    for (int i = 0; i < NUM_ENTRIES; i++)
                        if (resident[i] && resident_rank[i] > r)
                            resident_rank[i]--;
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    function automatic void add_row(logic [lpr_pkg::OP_W-1:0] op,
                                    logic [lpr_pkg::PROC_W-1:0] proc,
                                    logic [lpr_pkg::PAGE_W-1:0] page, bit typed,
                                    logic [lpr_pkg::ST_W-1:0] st,
                                    logic [lpr_pkg::PROC_W-1:0] vproc,
                                    logic [lpr_pkg::PAGE_W-1:0] vpage);
        t_stim_row row;
        row.op = op;
        row.proc = proc;
        row.page = page;
        row.typed = typed;
        row.want.status = st;
        row.want.victim_process = vproc;
        row.want.victim_page = vpage;
        directed_rows.push_back(row);
    endfunction

    task automatic transfer_in(t_stim_row row);
        int gap;
        lpr_pkg::t_result predicted;
        gap = tx_calm ? 0 : $urandom_range(0, 10);
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_operation <= row.op;
        i_process_id <= row.proc;
        i_page_number <= row.page;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predicted = lru_predict(row.op, row.proc, row.page);
        expected_results.push_back(row.typed ? row.want : predicted);
    endtask

    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_request > 0) begin
                i_stall <= 1'b1;
                hold_request--;
            end else if (rx_stall_left > 0) begin
                i_stall <= 1'b1;
                if (o_valid)
                    rx_stall_left--;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        lpr_pkg::t_result want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                $display("%0t: result with nothing expected: status %0d process %h page %h",
                         $time, o_status, o_victim_process, o_victim_page);
                mismatch_count++;
            end else begin
                want = expected_results.pop_front();
                if (o_status !== want.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, o_status);
                    mismatch_count++;
                end
                if (o_victim_process !== want.victim_process) begin
                    $display("%0t: victim process expected %h actual %h",
                             $time, want.victim_process, o_victim_process);
                    mismatch_count++;
                end
                if (o_victim_page !== want.victim_page) begin
                    $display("%0t: victim page expected %h actual %h",
                             $time, want.victim_page, o_victim_page);
                    mismatch_count++;
                end
            end
            rx_stall_left = rx_calm ? 0 : $urandom_range(0, 10);
        end
    end

    initial begin
        t_stim_row row;
        int access_pct;
        int pick;
        int k;
        for (int i = 0; i < NUM_ENTRIES; i++)
            resident[i] = 1'b0;

        add_row(lpr_pkg::OP_SELECT, '0, '0, 1'b1, lpr_pkg::ST_EMPTY, '0, '0);
        add_row(lpr_pkg::OP_REMOVE, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, lpr_pkg::ST_MISS, '0, '0);
        add_row(OP_UNUSED, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, lpr_pkg::ST_OK, '0, '0);
        add_row(lpr_pkg::OP_ACCESS, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, lpr_pkg::ST_OK, '0, '0);
        add_row(lpr_pkg::OP_ACCESS, 16'h0000, 32'h0000_0000, 1'b1, lpr_pkg::ST_OK, '0, '0);
        for (k = 2; k < NUM_ENTRIES; k++)
            add_row(lpr_pkg::OP_ACCESS, lpr_pkg::PROC_W'(k * 16'h0101),
                    32'h1000_0000 + lpr_pkg::PAGE_W'(k), 1'b1, lpr_pkg::ST_OK, '0, '0);
        add_row(lpr_pkg::OP_ACCESS, 16'h1234, 32'hDEAD_BEEF, 1'b1, lpr_pkg::ST_FULL, '0, '0);
        add_row(lpr_pkg::OP_ACCESS, 16'h0000, 32'h0000_0000, 1'b1, lpr_pkg::ST_OK, '0, '0);
        add_row(lpr_pkg::OP_SELECT, '0, '0, 1'b1, lpr_pkg::ST_OK, 16'hFFFF, 32'hFFFF_FFFF);
        add_row(lpr_pkg::OP_REMOVE, 16'h0000, 32'h0000_0000, 1'b1, lpr_pkg::ST_OK, '0, '0);
        add_row(lpr_pkg::OP_REMOVE, 16'h0000, 32'h0000_0000, 1'b1, lpr_pkg::ST_MISS, '0, '0);
        add_row(lpr_pkg::OP_SELECT, '0, '0, 1'b0, lpr_pkg::ST_OK, '0, '0);

        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[n])
            transfer_in(directed_rows[n]);

        for (int i = 0; i < POOL_SIZE; i++) begin
            pool_proc[i] = lpr_pkg::PROC_W'($urandom);
            pool_page[i] = $urandom;
        end
        access_pct = 65;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 60 == 0) begin
                case ($urandom_range(0, 2))
                    0: access_pct = 35;
                    1: access_pct = 65;
                    default: access_pct = 90;
                endcase
            end
            tx_calm = (n >= 100 && n < 160);
            rx_calm = (n >= 130 && n < 200);
            if (n == 250)
                hold_request = 300;
            if (n == 450) begin
                @(negedge i_clk);
                i_valid <= 1'b0;
                while (expected_results.size() != 0) @(posedge i_clk);
            end
            pick = $urandom_range(0, 99);
            if (pick < 3)
                row.op = OP_UNUSED;
            else if (pick < access_pct)
                row.op = lpr_pkg::OP_ACCESS;
            else if (pick < access_pct + (100 - access_pct) / 2)
                row.op = lpr_pkg::OP_SELECT;
            else
                row.op = lpr_pkg::OP_REMOVE;
            if ($urandom_range(0, 9) == 0) begin
                row.proc = lpr_pkg::PROC_W'($urandom);
                row.page = $urandom;
            end else begin
                k = $urandom_range(0, POOL_SIZE - 1);
                row.proc = pool_proc[k];
                row.page = pool_page[k];
            end
            row.typed = 1'b0;
            row.want = '0;
            transfer_in(row);
        end
        @(negedge i_clk);
        i_valid <= 1'b0;

        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
